FILE: rtl/bchd_pkg.sv
// Package with the shared constants and types of the button chord hold detector.
package bchd_pkg;

  localparam int NUM_BUTTONS_DEF = 28;
  localparam int NUM_CHORDS_DEF  = 6;

  localparam int SLOT_BITS      = 5;
  localparam int DELAY_BITS     = 16;
  localparam int US_PER_MS      = 1000;
  localparam int HOLD_US_BITS   = 26;
  localparam int TIME_BITS      = 63;
  localparam int CHORDS_PER_REG = 3;
  localparam int SLOT_REG_BITS  = 30;
  localparam int DELAY_REG_BITS = 48;
  localparam int MASK_BITS      = 28;
  localparam int ENABLE_BITS    = 6;
  localparam int CHORD_IDX_BITS = 3;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 48;

  localparam logic [DELAY_REG_BITS-1:0] DELAYS_LOW_RST =
      {16'd1000, 16'd1000, 16'd3000};
  localparam logic [DELAY_REG_BITS-1:0] DELAYS_HIGH_RST =
      {16'd1000, 16'd1000, 16'd1000};

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FIRST_BUTTON  = 3'd0,
    REG_SECOND_BUTTON = 3'd1,
    REG_DELAYS_LOW    = 3'd2,
    REG_DELAYS_HIGH   = 3'd3,
    REG_UNUSED_MASK   = 3'd4,
    REG_CHORD_ENABLE  = 3'd5
  } bchd_reg_e;

  // Settings of one chord, taken out of the packed registers.
  typedef struct packed {
    logic [SLOT_BITS-1:0]  first_slot;
    logic [SLOT_BITS-1:0]  second_slot;
    logic [DELAY_BITS-1:0] hold_ms;
    logic                  enable;
  } bchd_chord_cfg_t;

  // What one chord reports for the scan being evaluated.
  typedef struct packed {
    logic fire;
    logic armed;
  } bchd_chord_stat_t;

endpackage

FILE: rtl/bchd_scan_if.sv
// Interface of the scan channel: one button scan with its timestamp per word.
interface bchd_scan_if #(
  parameter int NumButtons = bchd_pkg::NUM_BUTTONS_DEF
);
  logic                           valid;
  logic                           ready;
  logic [NumButtons-1:0]          pressed_buttons;
  logic [bchd_pkg::TIME_BITS-1:0] now_us;

  modport source (output valid, output pressed_buttons, output now_us, input ready);
  modport sink   (input valid, input pressed_buttons, input now_us, output ready);
endinterface

FILE: rtl/bchd_result_if.sv
// Interface of the result channel: fired flag, chord index and armed flags per word.
interface bchd_result_if #(
  parameter int NumChords = bchd_pkg::NUM_CHORDS_DEF
);
  logic                                valid;
  logic                                ready;
  logic                                fired;
  logic [bchd_pkg::CHORD_IDX_BITS-1:0] fired_chord;
  logic [NumChords-1:0]                armed_chords;

  modport source (output valid, output fired, output fired_chord, output armed_chords,
                  input ready);
  modport sink   (input valid, input fired, input fired_chord, input armed_chords,
                  output ready);
endinterface

FILE: rtl/bchd_cfg_if.sv
// Interface of the configuration write channel: register index and data per word.
interface bchd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [bchd_pkg::CFG_IDX_BITS-1:0]  index;
  logic [bchd_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/bchd_chord_unit.sv
// One chord: hold check, arm flag, arming time and the hold timer compare.
module bchd_chord_unit #(
  parameter int NumButtons = bchd_pkg::NUM_BUTTONS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bchd_pkg::bchd_chord_cfg_t      cfg_i,
  input  logic [NumButtons-1:0]          used_i,
  input  logic [NumButtons-1:0]          pressed_i,
  input  logic [bchd_pkg::TIME_BITS-1:0] now_i,
  input  logic                           step_i,
  output bchd_pkg::bchd_chord_stat_t     stat_o
);

  logic                              armed_q, armed_d;
  logic [bchd_pkg::TIME_BITS-1:0]    start_q;
  logic [bchd_pkg::HOLD_US_BITS-1:0] hold_us_q;
  logic [NumButtons-1:0]             first_bit, second_bit;
  logic [bchd_pkg::TIME_BITS-1:0]    elapsed;
  logic                              held;
  logic                              expired;

  // Slot indices at or above the button count decode to no button at all.
  always_comb begin
    for (int k = 0; k < NumButtons; k++) begin
      first_bit[k]  = (cfg_i.first_slot == bchd_pkg::SLOT_BITS'(k));
      second_bit[k] = (cfg_i.second_slot == bchd_pkg::SLOT_BITS'(k));
    end
  end

  assign held = cfg_i.enable && (|(pressed_i & first_bit)) && (|(pressed_i & second_bit)) &&
                ((pressed_i & used_i & ~(first_bit | second_bit)) == '0);

  assign elapsed = now_i - start_q;
  assign expired = (now_i >= start_q) &&
                   (elapsed >= bchd_pkg::TIME_BITS'(hold_us_q));

  always_comb begin
    armed_d = armed_q;
    if (step_i) begin
      if (!held) begin
        armed_d = 1'b0;
      end else if (!armed_q) begin
        armed_d = 1'b1;
      end else if (expired) begin
        armed_d = 1'b0;
      end
    end
  end

  assign stat_o.fire  = step_i && held && armed_q && expired;
  assign stat_o.armed = armed_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
    end else begin
      armed_q <= armed_d;
    end
  end

  // The hold time in microseconds follows the delay register through a register.
  always_ff @(posedge clk_i) begin
    hold_us_q <= bchd_pkg::HOLD_US_BITS'(cfg_i.hold_ms * bchd_pkg::US_PER_MS);
    if (step_i && held && !armed_q) begin
      start_q <= now_i;
    end
  end

endmodule

FILE: rtl/button_chord_hold_detector.sv
// Top level of the button chord hold detector.
//
// The block takes one word per scan on the scan channel: a vector of button
// slots (1 = pressed) and a microsecond timestamp. It watches up to six
// two-button chords. A chord is held on a scan when it is enabled, both of its
// slots are pressed and no other slot outside the unused mask is pressed. The
// first held scan arms the chord and records the time; a later held scan fires
// it and disarms it once the time since arming reaches its delay in ms times
// 1000; a scan that does not hold the chord disarms it. Each scan yields
// exactly one result word with the fired flag, the lowest firing chord index
// (0 when nothing fired) and the armed flag of every chord after the scan.
// A scan can be accepted on every clock cycle while the result channel is not
// stalled; it passes through the input register and the result register that
// bracket the single pass of chord logic, and waits in the input register while
// a result word is stalled. Configuration writes are always accepted; a new hold
// delay takes effect for scans accepted from the cycle after the write. Slot
// indices at or above the button count name no button, so such a chord never
// arms. A held scan with a timestamp below the recorded arming time leaves the
// chord armed without firing.
module button_chord_hold_detector #(
  parameter int NumButtons = bchd_pkg::NUM_BUTTONS_DEF,
  parameter int NumChords  = bchd_pkg::NUM_CHORDS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  bchd_scan_if.sink             in_i,
  bchd_result_if.source         out_o,
  bchd_cfg_if.sink              cfg_i
);

  // Configuration registers.
  logic [bchd_pkg::SLOT_REG_BITS-1:0]  first_button_q;
  logic [bchd_pkg::SLOT_REG_BITS-1:0]  second_button_q;
  logic [bchd_pkg::DELAY_REG_BITS-1:0] delays_low_q;
  logic [bchd_pkg::DELAY_REG_BITS-1:0] delays_high_q;
  logic [bchd_pkg::MASK_BITS-1:0]      unused_mask_q;
  logic [bchd_pkg::ENABLE_BITS-1:0]    enable_q;

  // Input register holding the scan under evaluation.
  logic                           scan_valid_q;
  logic [NumButtons-1:0]          pressed_q;
  logic [bchd_pkg::TIME_BITS-1:0] now_q;

  // Result register.
  logic                                res_valid_q;
  logic                                fired_q, fired_d;
  logic [bchd_pkg::CHORD_IDX_BITS-1:0] fired_chord_q, fired_chord_d;
  logic [NumChords-1:0]                armed_q, armed_d;

  logic                               advance;
  logic [NumButtons-1:0]              used;
  logic [31:0]                        unused_wide;
  bchd_pkg::bchd_chord_cfg_t          chord_cfg [NumChords];
  bchd_pkg::bchd_chord_stat_t         chord_stat [NumChords];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_button_q  <= '0;
      second_button_q <= '0;
      delays_low_q    <= bchd_pkg::DELAYS_LOW_RST;
      delays_high_q   <= bchd_pkg::DELAYS_HIGH_RST;
      unused_mask_q   <= '0;
      enable_q        <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        bchd_pkg::REG_FIRST_BUTTON: begin
          first_button_q <= cfg_i.data[bchd_pkg::SLOT_REG_BITS-1:0];
        end
        bchd_pkg::REG_SECOND_BUTTON: begin
          second_button_q <= cfg_i.data[bchd_pkg::SLOT_REG_BITS-1:0];
        end
        bchd_pkg::REG_DELAYS_LOW: begin
          delays_low_q <= cfg_i.data[bchd_pkg::DELAY_REG_BITS-1:0];
        end
        bchd_pkg::REG_DELAYS_HIGH: begin
          delays_high_q <= cfg_i.data[bchd_pkg::DELAY_REG_BITS-1:0];
        end
        bchd_pkg::REG_UNUSED_MASK: begin
          unused_mask_q <= cfg_i.data[bchd_pkg::MASK_BITS-1:0];
        end
        bchd_pkg::REG_CHORD_ENABLE: begin
          enable_q <= cfg_i.data[bchd_pkg::ENABLE_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The scan moves into the result register when that register is free or
  // being emptied in the same cycle; the chord state updates on that move.
  assign advance    = scan_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !scan_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (in_i.ready) begin
        scan_valid_q <= in_i.valid;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      pressed_q <= in_i.pressed_buttons;
      now_q     <= in_i.now_us;
    end
    if (advance) begin
      fired_q       <= fired_d;
      fired_chord_q <= fired_chord_d;
      armed_q       <= armed_d;
    end
  end

  // Slots beyond the mask register are always counted as used.
  assign unused_wide = 32'(unused_mask_q);
  assign used        = ~unused_wide[NumButtons-1:0];

  for (genvar c = 0; c < NumChords; c++) begin : g_chord
    assign chord_cfg[c].first_slot  =
        first_button_q[c*bchd_pkg::SLOT_BITS +: bchd_pkg::SLOT_BITS];
    assign chord_cfg[c].second_slot =
        second_button_q[c*bchd_pkg::SLOT_BITS +: bchd_pkg::SLOT_BITS];
    assign chord_cfg[c].enable      = enable_q[c];
    if (c < bchd_pkg::CHORDS_PER_REG) begin : g_low
      assign chord_cfg[c].hold_ms =
          delays_low_q[c*bchd_pkg::DELAY_BITS +: bchd_pkg::DELAY_BITS];
    end else begin : g_high
      assign chord_cfg[c].hold_ms =
          delays_high_q[(c-bchd_pkg::CHORDS_PER_REG)*bchd_pkg::DELAY_BITS +:
                        bchd_pkg::DELAY_BITS];
    end

    bchd_chord_unit #(
      .NumButtons(NumButtons)
    ) u_chord (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cfg_i     (chord_cfg[c]),
      .used_i    (used),
      .pressed_i (pressed_q),
      .now_i     (now_q),
      .step_i    (advance),
      .stat_o    (chord_stat[c])
    );

    assign armed_d[c] = chord_stat[c].armed;
  end

  // When several chords fire together, the lowest index is reported.
  always_comb begin
    fired_d       = 1'b0;
    fired_chord_d = '0;
    for (int c = NumChords - 1; c >= 0; c--) begin
      if (chord_stat[c].fire) begin
        fired_d       = 1'b1;
        fired_chord_d = bchd_pkg::CHORD_IDX_BITS'(c);
      end
    end
  end

  assign out_o.valid        = res_valid_q;
  assign out_o.fired        = fired_q;
  assign out_o.fired_chord  = fired_chord_q;
  assign out_o.armed_chords = armed_q;

endmodule

FILE: rtl/bchd_checker.sv
// Port-level checker of the button chord hold detector and its bind statement.
module bchd_port_checker #(
  parameter int NumChords = bchd_pkg::NUM_CHORDS_DEF
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic                                fired_i,
  input logic [bchd_pkg::CHORD_IDX_BITS-1:0] fired_chord_i,
  input logic [NumChords-1:0]                armed_chords_i
);

  // A word with no firing chord reports chord index zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !fired_i |-> fired_chord_i == '0)
    else $error("fired_chord is not zero on a word without a firing chord");

  // A firing chord index names an existing chord.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && fired_i |-> 32'(fired_chord_i) < NumChords)
    else $error("fired_chord is out of range");

  // A chord that fires disarms on the same scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && fired_i |-> !armed_chords_i[fired_chord_i])
    else $error("fired chord is still shown armed");

  // A stalled result word holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(fired_i) &&
      $stable(fired_chord_i) && $stable(armed_chords_i))
    else $error("stalled result word changed");

endmodule

bind button_chord_hold_detector bchd_port_checker #(
  .NumChords(NumChords)
) u_bchd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .fired_i        (out_o.fired),
  .fired_chord_i  (out_o.fired_chord),
  .armed_chords_i (out_o.armed_chords)
);
